### rtl/igst_pkg.sv
package igst_pkg;

  // input command codes
  localparam logic [1:0] CMD_PACKET = 2'd0;
  localparam logic [1:0] CMD_SWEEP  = 2'd1;
  localparam logic [1:0] CMD_TICK   = 2'd2;

  // arrival side codes
  localparam logic [1:0] FROM_LAN = 2'd0;
  localparam logic [1:0] FROM_WAN = 2'd1;

  // protocol and igmp type codes
  localparam logic [7:0] PROTO_IGMP   = 8'd2;
  localparam logic [7:0] PROTO_UDP    = 8'd17;
  localparam logic [7:0] IGMP_QUERY   = 8'h11;
  localparam logic [7:0] IGMP_REP_V1  = 8'h12;
  localparam logic [7:0] IGMP_REP_V2  = 8'h16;
  localparam logic [7:0] IGMP_REP_V3  = 8'h22;
  localparam logic [7:0] IGMP_LEAVE   = 8'h17;

  localparam logic [31:0] ALL_HOSTS = 32'hE000_0001;

  // result action codes
  localparam logic [2:0] ACT_DROP     = 3'd0;
  localparam logic [2:0] ACT_CONSUME  = 3'd1;
  localparam logic [2:0] ACT_FORWARD  = 3'd2;
  localparam logic [2:0] ACT_REPORT   = 3'd3;
  localparam logic [2:0] ACT_LEAVE    = 3'd4;
  localparam logic [2:0] ACT_LAN_QUERY = 3'd5;

  // classified operation kinds
  localparam logic [3:0] K_DROP     = 4'd0;
  localparam logic [3:0] K_CONSUME  = 4'd1;
  localparam logic [3:0] K_LAN_QRY  = 4'd2;
  localparam logic [3:0] K_UDP      = 4'd3;
  localparam logic [3:0] K_LREPORT  = 4'd4;
  localparam logic [3:0] K_LEAVE    = 4'd5;
  localparam logic [3:0] K_WREPORT  = 4'd6;
  localparam logic [3:0] K_GQUERY   = 4'd7;
  localparam logic [3:0] K_SQUERY   = 4'd8;
  localparam logic [3:0] K_SWEEP    = 4'd9;
  localparam logic [3:0] K_TICK     = 4'd10;

  // result cap per item and result buffer addressing
  localparam int MAX_OUT = 32;
  localparam int OUT_IW  = 5;
  localparam int OUT_CW  = 6;

  typedef struct packed {
    logic [3:0]  kind;
    logic [31:0] key;
    logic [31:0] mask;
    logic [11:0] delay;
  } op_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [31:0] group;
    logic [31:0] ports;
    logic        full;
  } res_t;

endpackage

### rtl/igst_in_if.sv
interface igst_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [1:0]  from_port;
  logic [7:0]  ip_protocol;
  logic [7:0]  igmp_type;
  logic        header_complete;
  logic [31:0] dest_addr;
  logic [31:0] group_addr;
  logic [31:0] port_mask;
  logic [11:0] response_delay;

  modport source (output valid, command, from_port, ip_protocol, igmp_type,
                  header_complete, dest_addr, group_addr, port_mask, response_delay,
                  input ready);
  modport sink (input valid, command, from_port, ip_protocol, igmp_type,
                header_complete, dest_addr, group_addr, port_mask, response_delay,
                output ready);
endinterface

### rtl/igst_out_if.sv
interface igst_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [31:0] group_out;
  logic [31:0] ports_out;
  logic        table_full;
  logic [6:0]  group_count;
  logic        last;

  modport source (output valid, action, group_out, ports_out, table_full, group_count,
                  last, input ready);
  modport sink (input valid, action, group_out, ports_out, table_full, group_count,
                last, output ready);
endinterface

### rtl/igmp_snooping_group_table.sv
// a packet item that needs no table lookup passes pop and emit on its way to the
// output register; one that needs a lookup passes pop, match, execute and emit
// the engine takes a new item only once every result of the last one is emitted
// sweep and tick items walk the table, stopping early at the result cap, then emit,
// one table entry walked per cycle
// reset: synchronous; table empty, free slots in order, no result pending
module igmp_snooping_group_table #(
  parameter int ENTRIES    = 32,
  parameter int DELAY_BITS = 12
) (
  input  logic       clk,
  input  logic       rst,
  igst_in_if.sink    items,
  igst_out_if.source results
);

  igst_pkg::op_t op;
  logic          op_valid;
  logic          op_ready;

  igst_front u_front (
    .clk      (clk),
    .rst      (rst),
    .items    (items),
    .op       (op),
    .op_valid (op_valid),
    .op_ready (op_ready)
  );

  igst_back #(
    .ENTRIES    (ENTRIES),
    .DELAY_BITS (DELAY_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .op       (op),
    .op_valid (op_valid),
    .op_ready (op_ready),
    .results  (results)
  );

  // a full table only shows on a consumed report
  a_full_consumed: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.table_full |-> results.action == igst_pkg::ACT_CONSUME)
    else $error("table_full on a non-consumed result");

  // group count never exceeds the table size
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    results.valid |-> results.group_count <= 7'(ENTRIES))
    else $error("group count beyond table size");

  // only forwarded data carries a port mask
  a_ports_forward: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.action != igst_pkg::ACT_FORWARD |-> results.ports_out == 32'd0)
    else $error("port mask on a non-forward result");

endmodule

### rtl/igst_front.sv
module igst_front (
  input  logic              clk,
  input  logic              rst,
  igst_in_if.sink           items,
  output igst_pkg::op_t     op,
  output logic              op_valid,
  input  logic              op_ready
);

  igst_pkg::op_t cls;
  igst_pkg::op_t q [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       push;
  logic       pop;

  // classify the incoming item
  always_comb begin
    cls.kind  = igst_pkg::K_DROP;
    cls.key   = items.group_addr;
    cls.mask  = items.port_mask;
    cls.delay = items.response_delay;
    if (items.command == igst_pkg::CMD_SWEEP) begin
      cls.kind = igst_pkg::K_SWEEP;
    end else if (items.command == igst_pkg::CMD_TICK) begin
      cls.kind = igst_pkg::K_TICK;
    end else if (items.command != igst_pkg::CMD_PACKET) begin
      cls.kind = igst_pkg::K_DROP;
    end else if (items.dest_addr[31:28] != 4'hE) begin
      cls.kind = igst_pkg::K_DROP;
    end else if (items.ip_protocol == igst_pkg::PROTO_UDP) begin
      cls.key = items.dest_addr;
      if (items.from_port == igst_pkg::FROM_WAN) cls.kind = igst_pkg::K_UDP;
    end else if (items.ip_protocol != igst_pkg::PROTO_IGMP || !items.header_complete) begin
      cls.kind = igst_pkg::K_DROP;
    end else if (items.from_port == igst_pkg::FROM_LAN) begin
      if (items.igmp_type == igst_pkg::IGMP_REP_V1 ||
          items.igmp_type == igst_pkg::IGMP_REP_V2) begin
        cls.kind = igst_pkg::K_LREPORT;
      end else if (items.igmp_type == igst_pkg::IGMP_REP_V3) begin
        cls.kind = igst_pkg::K_LAN_QRY;
      end else if (items.igmp_type == igst_pkg::IGMP_LEAVE) begin
        cls.kind = igst_pkg::K_LEAVE;
      end
    end else if (items.from_port == igst_pkg::FROM_WAN) begin
      if (items.igmp_type == igst_pkg::IGMP_REP_V1 ||
          items.igmp_type == igst_pkg::IGMP_REP_V2) begin
        cls.kind = igst_pkg::K_WREPORT;
      end else if (items.igmp_type == igst_pkg::IGMP_QUERY) begin
        if (items.group_addr == 32'd0 && items.dest_addr == igst_pkg::ALL_HOSTS) begin
          cls.kind = igst_pkg::K_GQUERY;
        end else if (items.group_addr == items.dest_addr) begin
          cls.kind = igst_pkg::K_SQUERY;
          cls.key  = items.dest_addr;
        end else begin
          cls.kind = igst_pkg::K_CONSUME;
        end
      end
    end
  end

  // two-entry queue toward the table engine
  assign items.ready = (fill != 2'd2);
  assign push        = items.valid && items.ready;
  assign op_valid    = (fill != 2'd0);
  assign pop         = op_valid && op_ready;
  assign op          = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) q[wr_ptr] <= cls;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

### rtl/igst_back.sv
module igst_back #(
  parameter int ENTRIES    = 32,
  parameter int DELAY_BITS = 12
) (
  input  logic              clk,
  input  logic              rst,
  input  igst_pkg::op_t     op,
  input  logic              op_valid,
  output logic              op_ready,
  igst_out_if.source        results
);

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);
  localparam logic [CW-1:0] E_C = CW'(ENTRIES);
  localparam logic [IW-1:0] LAST_IDX = IW'(ENTRIES - 1);
  localparam logic [igst_pkg::OUT_CW-1:0] CAP = igst_pkg::OUT_CW'(igst_pkg::MAX_OUT);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MATCH = 3'd1;
  localparam logic [2:0] S_EXEC  = 3'd2;
  localparam logic [2:0] S_WALK  = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;
  localparam logic [2:0] S_EMIT  = 3'd5;

  logic [2:0] state;
  igst_pkg::op_t cur;

  // table: control bits reset, payload undefined until written
  logic                  valid_v    [ENTRIES];
  logic                  reported_v [ENTRIES];
  logic                  pending_v  [ENTRIES];
  logic [31:0]           grp        [ENTRIES];
  logic [31:0]           ports      [ENTRIES];
  logic [DELAY_BITS-1:0] cd         [ENTRIES];
  logic [IW-1:0]         stack      [ENTRIES];
  logic [CW-1:0]         held;

  logic [ENTRIES-1:0]    match;
  logic [IW-1:0]         hidx;
  logic                  hit;
  logic [IW-1:0]         widx;
  logic [igst_pkg::OUT_CW-1:0] rn;
  logic [igst_pkg::OUT_CW-1:0] ridx;

  // result buffer
  igst_pkg::res_t rbuf [igst_pkg::MAX_OUT];
  logic           res_we;
  logic [igst_pkg::OUT_IW-1:0] res_addr;
  igst_pkg::res_t res_d;

  logic [DELAY_BITS-1:0] dly;
  logic [31:0]           leave_ports;
  logic [IW-1:0]         ins_pos;
  logic [IW-1:0]         push_pos;
  logic                  sweep_hit;
  logic                  tick_fire;
  logic                  walk_brk;
  logic                  out_go;
  logic                  out_last;

  assign dly         = DELAY_BITS'(cur.delay);
  assign hit         = |match;
  assign leave_ports = ports[hidx] & ~cur.mask;
  assign ins_pos     = IW'(E_C - 1'b1 - held);
  assign push_pos    = IW'(E_C - held);
  assign sweep_hit   = valid_v[widx] && !reported_v[widx];
  assign tick_fire   = valid_v[widx] && pending_v[widx] && (cd[widx] == '0);
  assign walk_brk    = (rn == CAP) &&
                       ((cur.kind == igst_pkg::K_SWEEP) ? sweep_hit : tick_fire);
  assign op_ready    = (state == S_IDLE);
  assign out_go      = (state == S_EMIT) && (!results.valid || results.ready);
  assign out_last    = (ridx == rn - 1'b1);

  // one-hot match to index
  always_comb begin
    hidx = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      if (match[i]) hidx = hidx | IW'(i);
    end
  end

  // result produced in this cycle
  always_comb begin
    res_we   = 1'b0;
    res_addr = '0;
    res_d    = '{action: igst_pkg::ACT_CONSUME, group: 32'd0, ports: 32'd0, full: 1'b0};
    unique case (state)
      S_IDLE: begin
        if (op_valid && op.kind != igst_pkg::K_SWEEP && op.kind != igst_pkg::K_TICK &&
            op.kind != igst_pkg::K_UDP && op.kind != igst_pkg::K_LREPORT &&
            op.kind != igst_pkg::K_LEAVE && op.kind != igst_pkg::K_WREPORT &&
            op.kind != igst_pkg::K_SQUERY) begin
          res_we = 1'b1;
          if (op.kind == igst_pkg::K_DROP) res_d.action = igst_pkg::ACT_DROP;
          else if (op.kind == igst_pkg::K_LAN_QRY) res_d.action = igst_pkg::ACT_LAN_QUERY;
        end
      end
      S_EXEC: begin
        res_we = 1'b1;
        if (cur.kind == igst_pkg::K_UDP) begin
          if (hit) begin
            res_d.action = igst_pkg::ACT_FORWARD;
            res_d.group  = cur.key;
            res_d.ports  = ports[hidx];
          end else begin
            res_d.action = igst_pkg::ACT_DROP;
          end
        end else if (cur.kind == igst_pkg::K_LREPORT) begin
          if (!hit && held >= E_C) begin
            res_d.full = 1'b1;
          end else if (!hit) begin
            res_d.action = igst_pkg::ACT_REPORT;
            res_d.group  = cur.key;
          end
        end else if (cur.kind == igst_pkg::K_LEAVE) begin
          if (hit && leave_ports == 32'd0) begin
            res_d.action = igst_pkg::ACT_LEAVE;
            res_d.group  = cur.key;
          end
        end
      end
      S_WALK: begin
        res_addr = igst_pkg::OUT_IW'(rn);
        res_d.group = grp[widx];
        if (!walk_brk) begin
          if (cur.kind == igst_pkg::K_SWEEP) begin
            res_we       = sweep_hit;
            res_d.action = igst_pkg::ACT_LEAVE;
          end else begin
            res_we       = tick_fire;
            res_d.action = igst_pkg::ACT_REPORT;
          end
        end
      end
      S_FIN: begin
        res_we = (rn == '0);
      end
      default: begin
        res_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (res_we) rbuf[res_addr] <= res_d;
  end

  // table engine sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      held  <= '0;
      rn    <= '0;
      ridx  <= '0;
      widx  <= '0;
      for (int i = 0; i < ENTRIES; i++) begin
        valid_v[i]    <= 1'b0;
        reported_v[i] <= 1'b0;
        pending_v[i]  <= 1'b0;
        stack[i]      <= IW'(ENTRIES - 1 - i);
      end
    end else begin
      unique case (state)
        S_IDLE: begin
          if (op_valid) begin
            cur  <= op;
            rn   <= '0;
            ridx <= '0;
            widx <= '0;
            if (op.kind == igst_pkg::K_SWEEP || op.kind == igst_pkg::K_TICK) begin
              state <= S_WALK;
            end else if (op.kind == igst_pkg::K_UDP || op.kind == igst_pkg::K_LREPORT ||
                         op.kind == igst_pkg::K_LEAVE || op.kind == igst_pkg::K_WREPORT ||
                         op.kind == igst_pkg::K_SQUERY) begin
              state <= S_MATCH;
            end else begin
              // general query arms every held group not yet pending in one pass
              if (op.kind == igst_pkg::K_GQUERY) begin
                for (int i = 0; i < ENTRIES; i++) begin
                  if (valid_v[i] && !pending_v[i]) begin
                    pending_v[i] <= 1'b1;
                    cd[i]        <= DELAY_BITS'(op.delay);
                  end
                end
              end
              rn    <= igst_pkg::OUT_CW'(1);
              state <= S_EMIT;
            end
          end
        end
        S_MATCH: begin
          for (int i = 0; i < ENTRIES; i++) begin
            match[i] <= valid_v[i] && (grp[i] == cur.key);
          end
          state <= S_EXEC;
        end
        S_EXEC: begin
          rn    <= igst_pkg::OUT_CW'(1);
          state <= S_EMIT;
          if (cur.kind == igst_pkg::K_LREPORT) begin
            if (hit) begin
              ports[hidx]      <= ports[hidx] | cur.mask;
              reported_v[hidx] <= 1'b1;
            end else if (held < E_C) begin
              held                  <= held + 1'b1;
              valid_v[stack[ins_pos]]    <= 1'b1;
              grp[stack[ins_pos]]        <= cur.key;
              ports[stack[ins_pos]]      <= cur.mask;
              reported_v[stack[ins_pos]] <= 1'b1;
              pending_v[stack[ins_pos]]  <= 1'b0;
              cd[stack[ins_pos]]         <= '0;
            end
          end else if (cur.kind == igst_pkg::K_LEAVE) begin
            if (hit) begin
              ports[hidx] <= leave_ports;
              if (leave_ports == 32'd0) begin
                valid_v[hidx]    <= 1'b0;
                reported_v[hidx] <= 1'b0;
                pending_v[hidx]  <= 1'b0;
                stack[push_pos]  <= hidx;
                held             <= held - 1'b1;
              end
            end
          end else if (cur.kind == igst_pkg::K_WREPORT) begin
            if (hit) pending_v[hidx] <= 1'b0;
          end else if (cur.kind == igst_pkg::K_SQUERY) begin
            if (hit && !pending_v[hidx]) begin
              pending_v[hidx] <= 1'b1;
              cd[hidx]        <= dly;
            end
          end
        end
        S_WALK: begin
          if (walk_brk) begin
            state <= S_FIN;
          end else begin
            if (cur.kind == igst_pkg::K_SWEEP) begin
              if (sweep_hit) begin
                valid_v[widx]   <= 1'b0;
                pending_v[widx] <= 1'b0;
                stack[push_pos] <= widx;
                held            <= held - 1'b1;
                rn              <= rn + 1'b1;
              end
              reported_v[widx] <= 1'b0;
            end else if (valid_v[widx] && pending_v[widx]) begin
              if (tick_fire) begin
                pending_v[widx] <= 1'b0;
                rn              <= rn + 1'b1;
              end else begin
                cd[widx] <= cd[widx] - 1'b1;
              end
            end
            if (widx == LAST_IDX) state <= S_FIN;
            else widx <= widx + 1'b1;
          end
        end
        S_FIN: begin
          if (rn == '0) rn <= igst_pkg::OUT_CW'(1);
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (out_go) begin
            ridx <= ridx + 1'b1;
            if (out_last) state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // output register, loaded from the result buffer
  always_ff @(posedge clk) begin
    if (out_go) begin
      results.action      <= rbuf[igst_pkg::OUT_IW'(ridx)].action;
      results.group_out   <= rbuf[igst_pkg::OUT_IW'(ridx)].group;
      results.ports_out   <= rbuf[igst_pkg::OUT_IW'(ridx)].ports;
      results.table_full  <= rbuf[igst_pkg::OUT_IW'(ridx)].full;
      results.group_count <= 7'(held);
      results.last        <= out_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (out_go) begin
      results.valid <= 1'b1;
    end else if (results.ready) begin
      results.valid <= 1'b0;
    end
  end

endmodule

### tb/sv/tb_igmp_snooping_group_table.sv
`timescale 1ns / 1ps

module tb_igmp_snooping_group_table;

  localparam int NUM_SLOTS = 32;
  localparam int DLY_BITS  = 12;

  // one input item as seen at the transfer
  typedef struct {
    logic [1:0]  command;
    logic [1:0]  from_port;
    logic [7:0]  ip_protocol;
    logic [7:0]  igmp_type;
    logic        header_complete;
    logic [31:0] dest_addr;
    logic [31:0] group_addr;
    logic [31:0] port_mask;
    logic [11:0] response_delay;
  } pkt_item_t;

  // one result item
  typedef struct {
    logic [2:0]  action;
    logic [31:0] group_out;
    logic [31:0] ports_out;
    logic        table_full;
    logic [6:0]  group_count;
    logic        last;
  } table_res_t;

  // shadow group table and the queue of predicted results
  class group_table_sb;
    logic [31:0] grp [NUM_SLOTS];
    bit          vld [NUM_SLOTS];
    logic [31:0] prt [NUM_SLOTS];
    bit          rep [NUM_SLOTS];
    bit          pend [NUM_SLOTS];
    logic [11:0] cnt [NUM_SLOTS];
    logic [4:0]  free_slots [NUM_SLOTS];
    int          held;
    table_res_t  pending_res [$];
    table_res_t  step_res [$];
    int          mismatches;
    int          checked;
    int          reports_seen;
    int          leaves_seen;
    int          fulls_seen;

    function new();
      for (int i = 0; i < NUM_SLOTS; i++) begin
        vld[i] = 0; rep[i] = 0; pend[i] = 0;
        grp[i] = '0; prt[i] = '0; cnt[i] = '0;
        free_slots[i] = 5'(NUM_SLOTS - 1 - i);
      end
      held = 0;
      mismatches = 0;
      checked = 0;
      reports_seen = 0;
      leaves_seen = 0;
      fulls_seen = 0;
    endfunction

    function int lookup(logic [31:0] g);
      for (int i = 0; i < NUM_SLOTS; i++)
        if (vld[i] && grp[i] == g) return i;
      return -1;
    endfunction

    function void free_slot(int i);
      vld[i] = 0; rep[i] = 0; pend[i] = 0;
      if (held > 0) begin
        free_slots[NUM_SLOTS - held] = 5'(i);
        held--;
      end
    endfunction

    function void emit(logic [2:0] act, logic [31:0] g, logic [31:0] p, logic f);
      table_res_t r;
      r.action = act; r.group_out = g; r.ports_out = p; r.table_full = f;
      r.group_count = '0; r.last = 0;
      step_res.push_back(r);
    endfunction

    function void arm_slot(int i, logic [11:0] d);
      if (!pend[i]) begin
        pend[i] = 1;
        cnt[i] = d;
      end
    endfunction

    // packet classification and table update
    function void packet_step(pkt_item_t it);
      int i;
      logic [11:0] d;
      d = it.response_delay[DLY_BITS-1:0];
      if (it.dest_addr[31:28] != 4'hE) begin
        emit(igst_pkg::ACT_DROP, 0, 0, 0);
      end else if (it.ip_protocol == igst_pkg::PROTO_UDP) begin
        i = (it.from_port == igst_pkg::FROM_WAN) ? lookup(it.dest_addr) : -1;
        if (i >= 0) emit(igst_pkg::ACT_FORWARD, it.dest_addr, prt[i], 0);
        else emit(igst_pkg::ACT_DROP, 0, 0, 0);
      end else if (it.ip_protocol != igst_pkg::PROTO_IGMP || !it.header_complete) begin
        emit(igst_pkg::ACT_DROP, 0, 0, 0);
      end else if (it.from_port == igst_pkg::FROM_LAN) begin
        if (it.igmp_type == igst_pkg::IGMP_REP_V1 || it.igmp_type == igst_pkg::IGMP_REP_V2) begin
          i = lookup(it.group_addr);
          if (i >= 0) begin
            prt[i] = prt[i] | it.port_mask;
            rep[i] = 1;
            emit(igst_pkg::ACT_CONSUME, 0, 0, 0);
          end else if (held >= NUM_SLOTS) begin
            emit(igst_pkg::ACT_CONSUME, 0, 0, 1);
          end else begin
            i = free_slots[NUM_SLOTS - 1 - held];
            held++;
            vld[i] = 1; grp[i] = it.group_addr; prt[i] = it.port_mask;
            rep[i] = 1; pend[i] = 0; cnt[i] = '0;
            emit(igst_pkg::ACT_REPORT, it.group_addr, 0, 0);
          end
        end else if (it.igmp_type == igst_pkg::IGMP_REP_V3) begin
          emit(igst_pkg::ACT_LAN_QUERY, 0, 0, 0);
        end else if (it.igmp_type == igst_pkg::IGMP_LEAVE) begin
          i = lookup(it.group_addr);
          if (i >= 0) begin
            prt[i] = prt[i] & ~it.port_mask;
            if (prt[i] == 0) begin
              free_slot(i);
              emit(igst_pkg::ACT_LEAVE, it.group_addr, 0, 0);
              return;
            end
          end
          emit(igst_pkg::ACT_CONSUME, 0, 0, 0);
        end else begin
          emit(igst_pkg::ACT_DROP, 0, 0, 0);
        end
      end else if (it.from_port == igst_pkg::FROM_WAN) begin
        if (it.igmp_type == igst_pkg::IGMP_REP_V1 || it.igmp_type == igst_pkg::IGMP_REP_V2) begin
          i = lookup(it.group_addr);
          if (i >= 0) pend[i] = 0;
          emit(igst_pkg::ACT_CONSUME, 0, 0, 0);
        end else if (it.igmp_type == igst_pkg::IGMP_QUERY) begin
          if (held > 0) begin
            if (it.group_addr == 0 && it.dest_addr == igst_pkg::ALL_HOSTS) begin
              for (int k = 0; k < NUM_SLOTS; k++) if (vld[k]) arm_slot(k, d);
            end else if (it.group_addr == it.dest_addr) begin
              i = lookup(it.dest_addr);
              if (i >= 0) arm_slot(i, d);
            end
          end
          emit(igst_pkg::ACT_CONSUME, 0, 0, 0);
        end else begin
          emit(igst_pkg::ACT_DROP, 0, 0, 0);
        end
      end else begin
        emit(igst_pkg::ACT_DROP, 0, 0, 0);
      end
    endfunction

    function void sweep_step();
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (vld[i] && !rep[i]) begin
          if (step_res.size() >= igst_pkg::MAX_OUT) break;
          emit(igst_pkg::ACT_LEAVE, grp[i], 0, 0);
          free_slot(i);
        end
        rep[i] = 0;
      end
      if (step_res.size() == 0) emit(igst_pkg::ACT_CONSUME, 0, 0, 0);
    endfunction

    function void tick_step();
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (!vld[i] || !pend[i]) continue;
        if (cnt[i] == 0) begin
          if (step_res.size() >= igst_pkg::MAX_OUT) break;
          pend[i] = 0;
          emit(igst_pkg::ACT_REPORT, grp[i], 0, 0);
        end else begin
          cnt[i] = cnt[i] - 1;
        end
      end
      if (step_res.size() == 0) emit(igst_pkg::ACT_CONSUME, 0, 0, 0);
    endfunction

    // note an accepted input item and queue its predicted results
    function void note_item(pkt_item_t it);
      table_res_t r;
      step_res.delete();
      case (it.command)
        igst_pkg::CMD_PACKET: packet_step(it);
        igst_pkg::CMD_SWEEP:  sweep_step();
        igst_pkg::CMD_TICK:   tick_step();
        default:              emit(igst_pkg::ACT_DROP, 0, 0, 0);
      endcase
      for (int k = 0; k < step_res.size(); k++) begin
        r = step_res[k];
        r.group_count = 7'(held);
        r.last = (k == step_res.size() - 1);
        pending_res.push_back(r);
      end
    endfunction

    // compare one accepted result with the oldest prediction
    function void check_result(table_res_t got);
      table_res_t exp_r;
      checked++;
      if (got.action == igst_pkg::ACT_REPORT) reports_seen++;
      if (got.action == igst_pkg::ACT_LEAVE) leaves_seen++;
      if (got.table_full) fulls_seen++;
      if (pending_res.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: action %0d group %h", got.action, got.group_out);
        return;
      end
      exp_r = pending_res.pop_front();
      if (got.action !== exp_r.action || got.group_out !== exp_r.group_out ||
          got.ports_out !== exp_r.ports_out || got.table_full !== exp_r.table_full ||
          got.group_count !== exp_r.group_count || got.last !== exp_r.last) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch: exp act %0d grp %h prt %h full %0d cnt %0d last %0d",
                   exp_r.action, exp_r.group_out, exp_r.ports_out, exp_r.table_full,
                   exp_r.group_count, exp_r.last);
          $display("          got act %0d grp %h prt %h full %0d cnt %0d last %0d",
                   got.action, got.group_out, got.ports_out, got.table_full,
                   got.group_count, got.last);
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  igst_in_if  items ();
  igst_out_if results ();

  igmp_snooping_group_table #(.ENTRIES(NUM_SLOTS), .DELAY_BITS(DLY_BITS)) dut (
    .clk(clk), .rst(rst), .items(items.sink), .results(results.source)
  );

  group_table_sb sb;
  bit            calm;
  int            items_sent;
  logic [31:0]   group_pool [8];

  initial begin
    clk = 0;
  end
  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  // input monitor and result checker, sampled at the edge
  always @(posedge clk) begin
    if (!rst) begin
      if (items.valid && items.ready) begin
        pkt_item_t it;
        it.command = items.command; it.from_port = items.from_port;
        it.ip_protocol = items.ip_protocol; it.igmp_type = items.igmp_type;
        it.header_complete = items.header_complete; it.dest_addr = items.dest_addr;
        it.group_addr = items.group_addr; it.port_mask = items.port_mask;
        it.response_delay = items.response_delay;
        sb.note_item(it);
      end
      if (results.valid && results.ready) begin
        table_res_t r;
        r.action = results.action; r.group_out = results.group_out;
        r.ports_out = results.ports_out; r.table_full = results.table_full;
        r.group_count = results.group_count; r.last = results.last;
        sb.check_result(r);
      end
    end
  end

  // result side stall
  always @(posedge clk) begin
    if (rst) results.ready <= 1'b0;
    else results.ready <= calm ? 1'b1 : ($urandom_range(99) >= 13);
  end

  // drive one item and hold it until the transfer
  task automatic send_item(pkt_item_t it);
    while (!calm && $urandom_range(99) < 13) begin
      items.valid <= 1'b0;
      @(posedge clk);
    end
    items.valid <= 1'b1;
    items.command <= it.command; items.from_port <= it.from_port;
    items.ip_protocol <= it.ip_protocol; items.igmp_type <= it.igmp_type;
    items.header_complete <= it.header_complete; items.dest_addr <= it.dest_addr;
    items.group_addr <= it.group_addr; items.port_mask <= it.port_mask;
    items.response_delay <= it.response_delay;
    @(posedge clk);
    while (!items.ready) @(posedge clk);
    items_sent++;
  endtask

  function automatic pkt_item_t make_item(logic [1:0] cmd, logic [1:0] from,
                                          logic [7:0] proto, logic [7:0] ty,
                                          logic [31:0] dst, logic [31:0] grp,
                                          logic [31:0] msk, logic [11:0] dly);
    pkt_item_t it;
    it.command = cmd; it.from_port = from; it.ip_protocol = proto; it.igmp_type = ty;
    it.header_complete = 1'b1; it.dest_addr = dst; it.group_addr = grp;
    it.port_mask = msk; it.response_delay = dly;
    return it;
  endfunction

  function automatic logic [31:0] pick_group();
    return group_pool[$urandom_range(7)];
  endfunction

  // random item, mostly well-formed igmp traffic on a small group pool
  function automatic pkt_item_t random_item();
    pkt_item_t it;
    logic [31:0] g;
    int sel;
    g = pick_group();
    sel = $urandom_range(99);
    it = make_item(igst_pkg::CMD_PACKET, igst_pkg::FROM_LAN, igst_pkg::PROTO_IGMP,
                   igst_pkg::IGMP_REP_V2, g, g,
                   $urandom_range(3) == 0 ? $urandom : 32'(1) << $urandom_range(31),
                   $urandom_range(3) == 0 ? 12'($urandom) : 12'($urandom_range(4)));
    if (sel < 28) begin
      it.igmp_type = $urandom_range(1) ? igst_pkg::IGMP_REP_V1 : igst_pkg::IGMP_REP_V2;
    end else if (sel < 42) it.igmp_type = igst_pkg::IGMP_LEAVE;
    else if (sel < 50) begin
      it.from_port = igst_pkg::FROM_WAN; it.igmp_type = igst_pkg::IGMP_QUERY;
      if ($urandom_range(1)) begin
        it.group_addr = 0; it.dest_addr = igst_pkg::ALL_HOSTS;
      end
    end else if (sel < 55) begin
      it.from_port = igst_pkg::FROM_WAN;
      it.igmp_type = $urandom_range(1) ? igst_pkg::IGMP_REP_V1 : igst_pkg::IGMP_REP_V2;
    end else if (sel < 63) begin
      it.from_port = igst_pkg::FROM_WAN; it.ip_protocol = igst_pkg::PROTO_UDP;
    end else if (sel < 68) it.command = igst_pkg::CMD_SWEEP;
    else if (sel < 82) it.command = igst_pkg::CMD_TICK;
    else if (sel < 85) it.igmp_type = igst_pkg::IGMP_REP_V3;
    else if (sel < 87) it.command = 2'd3;
    else begin
      // noise
      it.from_port = 2'($urandom);
      it.ip_protocol = $urandom_range(1) ? 8'($urandom) : igst_pkg::PROTO_IGMP;
      it.igmp_type = 8'($urandom); it.header_complete = 1'($urandom);
      it.dest_addr = $urandom_range(1) ? $urandom : g;
      it.group_addr = $urandom_range(1) ? $urandom : g;
      it.port_mask = $urandom; it.response_delay = 12'($urandom);
    end
    return it;
  endfunction

  initial begin
    pkt_item_t it;
    int guard;
    sb = new();
    calm = 0;
    items_sent = 0;
    rst = 1'b1;
    items.valid <= 1'b0;
    items.command <= igst_pkg::CMD_PACKET; items.from_port <= igst_pkg::FROM_LAN;
    items.ip_protocol <= '0; items.igmp_type <= '0; items.header_complete <= 1'b0;
    items.dest_addr <= '0; items.group_addr <= '0; items.port_mask <= '0;
    items.response_delay <= '0;
    for (int k = 0; k < 8; k++) group_pool[k] = {4'hE, 28'($urandom)};
    group_pool[0] = 32'hEFFF_FFFF;
    group_pool[1] = 32'hE000_0000;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: every rule and corner
    send_item(make_item(igst_pkg::CMD_SWEEP, igst_pkg::FROM_LAN, 0, 0, 0, 0, 0, 0));
    send_item(make_item(igst_pkg::CMD_TICK, igst_pkg::FROM_LAN, 0, 0, 0, 0, 0, 0));
    send_item(make_item(2'd3, 2'd3, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                        32'hFFFF_FFFF, 12'hFFF));
    send_item(make_item(igst_pkg::CMD_PACKET, igst_pkg::FROM_LAN, igst_pkg::PROTO_IGMP,
                        igst_pkg::IGMP_REP_V1, 32'hDFFF_FFFF, group_pool[0], 1, 0));
    send_item(make_item(igst_pkg::CMD_PACKET, igst_pkg::FROM_WAN, igst_pkg::PROTO_IGMP,
                        igst_pkg::IGMP_QUERY, igst_pkg::ALL_HOSTS, 0, 0, 5));
    send_item(make_item(igst_pkg::CMD_PACKET, igst_pkg::FROM_LAN, igst_pkg::PROTO_IGMP,
                        igst_pkg::IGMP_REP_V1, group_pool[0], group_pool[0],
                        32'hFFFF_FFFF, 0));
    send_item(make_item(igst_pkg::CMD_PACKET, igst_pkg::FROM_LAN, igst_pkg::PROTO_IGMP,
                        igst_pkg::IGMP_REP_V2, group_pool[0], group_pool[0], 32'h1, 0));
    send_item(make_item(igst_pkg::CMD_PACKET, igst_pkg::FROM_LAN, igst_pkg::PROTO_IGMP,
                        igst_pkg::IGMP_REP_V2, group_pool[1], group_pool[1], 32'h3, 0));
    send_item(make_item(igst_pkg::CMD_PACKET, igst_pkg::FROM_WAN, igst_pkg::PROTO_UDP, 0,
                        group_pool[0], 0, 0, 0));
    send_item(make_item(igst_pkg::CMD_PACKET, igst_pkg::FROM_LAN, igst_pkg::PROTO_UDP, 0,
                        group_pool[0], 0, 0, 0));
    send_item(make_item(igst_pkg::CMD_PACKET, igst_pkg::FROM_LAN, igst_pkg::PROTO_IGMP,
                        igst_pkg::IGMP_REP_V3, 32'hE000_0016, 0, 0, 0));
    it = make_item(igst_pkg::CMD_PACKET, igst_pkg::FROM_LAN, igst_pkg::PROTO_IGMP,
                   igst_pkg::IGMP_REP_V2, group_pool[2], group_pool[2], 1, 0);
    it.header_complete = 0;
    send_item(it);
    send_item(make_item(igst_pkg::CMD_PACKET, 2'd2, igst_pkg::PROTO_IGMP,
                        igst_pkg::IGMP_REP_V2, group_pool[2], group_pool[2], 1, 0));
    send_item(make_item(igst_pkg::CMD_PACKET, igst_pkg::FROM_LAN, igst_pkg::PROTO_IGMP,
                        igst_pkg::IGMP_LEAVE, group_pool[1], group_pool[1], 32'h1, 0));
    send_item(make_item(igst_pkg::CMD_PACKET, igst_pkg::FROM_LAN, igst_pkg::PROTO_IGMP,
                        igst_pkg::IGMP_LEAVE, group_pool[3], group_pool[3], 32'h1, 0));
    send_item(make_item(igst_pkg::CMD_PACKET, igst_pkg::FROM_WAN, igst_pkg::PROTO_IGMP,
                        igst_pkg::IGMP_QUERY, igst_pkg::ALL_HOSTS, 0, 0, 12'hFFF));
    send_item(make_item(igst_pkg::CMD_PACKET, igst_pkg::FROM_WAN, igst_pkg::PROTO_IGMP,
                        igst_pkg::IGMP_QUERY, group_pool[1], group_pool[1], 0, 0));
    send_item(make_item(igst_pkg::CMD_PACKET, igst_pkg::FROM_WAN, igst_pkg::PROTO_IGMP,
                        igst_pkg::IGMP_QUERY, group_pool[0], group_pool[1], 0, 0));
    send_item(make_item(igst_pkg::CMD_PACKET, igst_pkg::FROM_WAN, igst_pkg::PROTO_IGMP,
                        igst_pkg::IGMP_REP_V1, group_pool[0], group_pool[0], 0, 0));
    send_item(make_item(igst_pkg::CMD_TICK, igst_pkg::FROM_LAN, 0, 0, 0, 0, 0, 0));
    send_item(make_item(igst_pkg::CMD_TICK, igst_pkg::FROM_LAN, 0, 0, 0, 0, 0, 0));
    send_item(make_item(igst_pkg::CMD_PACKET, igst_pkg::FROM_WAN, igst_pkg::PROTO_IGMP,
                        8'h00, group_pool[0], group_pool[0], 0, 0));
    send_item(make_item(igst_pkg::CMD_SWEEP, igst_pkg::FROM_LAN, 0, 0, 0, 0, 0, 0));
    send_item(make_item(igst_pkg::CMD_SWEEP, igst_pkg::FROM_LAN, 0, 0, 0, 0, 0, 0));

    // fill the table past full, then arm all and fire on one tick, then sweep
    for (int k = 0; k < NUM_SLOTS + 2; k++)
      send_item(make_item(igst_pkg::CMD_PACKET, igst_pkg::FROM_LAN, igst_pkg::PROTO_IGMP,
                          igst_pkg::IGMP_REP_V2, 32'hE100_0000 + k, 32'hE100_0000 + k,
                          32'(k + 1), 0));
    send_item(make_item(igst_pkg::CMD_PACKET, igst_pkg::FROM_WAN, igst_pkg::PROTO_IGMP,
                        igst_pkg::IGMP_QUERY, igst_pkg::ALL_HOSTS, 0, 0, 0));
    send_item(make_item(igst_pkg::CMD_TICK, igst_pkg::FROM_LAN, 0, 0, 0, 0, 0, 0));
    send_item(make_item(igst_pkg::CMD_SWEEP, igst_pkg::FROM_LAN, 0, 0, 0, 0, 0, 0));
    send_item(make_item(igst_pkg::CMD_SWEEP, igst_pkg::FROM_LAN, 0, 0, 0, 0, 0, 0));

    // random traffic, a quiet stretch in the middle
    for (int n = 0; n < 390; n++) begin
      calm = (n >= 150 && n < 230);
      send_item(random_item());
    end
    calm = 0;
    items.valid <= 1'b0;

    guard = 0;
    while (sb.pending_res.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (100) @(posedge clk);

    $display("covered %0d items, %0d results checked: %0d upstream reports, %0d leaves,",
             items_sent, sb.checked, sb.reports_seen, sb.leaves_seen);
    $display("%0d table-full reports, %0d mismatches", sb.fulls_seen, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending_res.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      if (sb.pending_res.size() != 0)
        $display("%0d expected results never arrived", sb.pending_res.size());
      $display("TEST FAILED");
    end
    $finish;
  end

  // run limit
  initial begin
    #20ms;
    $display("timeout");
    $display("TEST FAILED");
    $finish;
  end

endmodule

### sim.f
rtl/igst_pkg.sv
rtl/igst_in_if.sv
rtl/igst_out_if.sv
rtl/igst_front.sv
rtl/igst_back.sv
rtl/igmp_snooping_group_table.sv
tb/sv/tb_igmp_snooping_group_table.sv
